/* hw/rtl/irdp_pkg.sv */
// shared types, constants and helper functions for the image reply deframer
// and pixel packer; used by every module of the block, depends on nothing
`default_nettype none

package irdp_pkg;

    // parameter defaults
    localparam int unsigned MAX_DIM_DEFAULT = 4096;
    localparam int unsigned MSG_MAX_DEFAULT = 511;

    // request codes carried on the slave tuser
    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // result kinds carried on the master tuser
    localparam logic [2:0] KIND_PIXEL  = 3'd0;
    localparam logic [2:0] KIND_DONE   = 3'd1;
    localparam logic [2:0] KIND_MSG    = 3'd2;
    localparam logic [2:0] KIND_ERREND = 3'd3;
    localparam logic [2:0] KIND_BADMAG = 3'd4;
    localparam logic [2:0] KIND_CLOSED = 3'd5;
    localparam logic [2:0] KIND_OVERSZ = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

    // frame layout
    localparam logic [31:0] MAGIC_WORD   = 32'h4632_4B31;
    localparam logic [12:0] SIZE_SAT     = 13'h1FFF;
    localparam logic [4:0]  HDR_MAGIC_END  = 5'd4;
    localparam logic [4:0]  HDR_STATUS_END = 5'd8;
    localparam logic [4:0]  HDR_WIDTH_END  = 5'd12;
    localparam logic [4:0]  HDR_HEIGHT_END = 5'd16;
    localparam logic [4:0]  HDR_SEED_END   = 5'd20;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;

    // master tdata packing
    localparam int unsigned OUT_FIELDS_W = 154;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef struct packed {
        logic [31:0] mask;
        logic [4:0]  shift;
        logic [5:0]  bits;
    } chan_cfg_t;

    typedef struct packed {
        chan_cfg_t red;
        chan_cfg_t green;
        chan_cfg_t blue;
    } pix_cfg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        pixel_value;
        logic [11:0]        pixel_x;
        logic [11:0]        pixel_y;
        logic [7:0]         message_byte;
        logic signed [31:0] status_code;
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
        logic [31:0]        frame_seed;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } res_push_t;

    // position of the lowest set bit, zero for an empty mask
    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) pos = 5'(i);
        end
        return pos;
    endfunction

    // length of the run of ones starting at bit zero
    function automatic logic [5:0] trailing_ones(input logic [31:0] v);
        logic [5:0] len;
        len = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (!v[i]) len = 6'(i);
        end
        return len;
    endfunction

    function automatic chan_cfg_t decode_chan(input logic [31:0] mask);
        chan_cfg_t c;
        c.mask  = mask;
        c.shift = lowest_set(mask);
        c.bits  = trailing_ones(mask >> c.shift);
        return c;
    endfunction

    // scale one 8-bit component to the channel width and place it
    function automatic logic [31:0] chan_pack(input chan_cfg_t c, input logic [7:0] comp);
        logic [31:0] v;
        if (c.bits >= 6'd8) v = {24'd0, comp} << (c.bits - 6'd8);
        else                v = {24'd0, comp} >> (6'd8 - c.bits);
        return (v << c.shift) & c.mask;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/irdp_chan_cfg.sv */
// configuration registers: channel masks on the apb port and their decoded
// shift and width; depends on irdp_pkg
`default_nettype none

module irdp_chan_cfg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output irdp_pkg::pix_cfg_t    cfg
);
    import irdp_pkg::*;

    pix_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // decode happens once per write so the pixel path sees plain shift amounts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red   <= decode_chan(RED_MASK_RST);
            cfg_reg.green <= decode_chan(GREEN_MASK_RST);
            cfg_reg.blue  <= decode_chan(BLUE_MASK_RST);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RED:   cfg_reg.red   <= decode_chan(pwdata);
                REG_GREEN: cfg_reg.green <= decode_chan(pwdata);
                REG_BLUE:  cfg_reg.blue  <= decode_chan(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RED:   prdata = cfg_reg.red.mask;
            REG_GREEN: prdata = cfg_reg.green.mask;
            REG_BLUE:  prdata = cfg_reg.blue.mask;
            default:   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/irdp_parser.sv */
// input beat register, reply frame parser and pixel packer; produces up to two
// result entries per beat; depends on irdp_pkg
`default_nettype none

module irdp_parser #(
    parameter int unsigned MAX_DIM = irdp_pkg::MAX_DIM_DEFAULT,
    parameter int unsigned MSG_MAX = irdp_pkg::MSG_MAX_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic [1:0]          in_req,
    input  wire logic [7:0]          in_byte,
    output logic                     in_ready,
    input  wire irdp_pkg::pix_cfg_t  cfg,
    input  wire logic                room,
    output irdp_pkg::res_push_t      push
);
    import irdp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEAD, PH_BADMAGIC, PH_ERRLEN, PH_MSG, PH_OKHDR, PH_PIX
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] status_reg, status_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] rem_reg, rem_next;
    logic [8:0]  emitted_reg, emitted_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [1:0]  chan_reg, chan_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;

    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    logic [31:0] acc_shift;
    logic [4:0]  cnt_inc;
    logic [31:0] rem_dec;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic [12:0] size_sat;
    logic [31:0] pixel;
    logic [1:0]  n;
    res_t        e0, e1;

    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_req_reg  <= in_req;
            in_byte_reg <= in_byte;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        status_next  = status_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        seed_next    = seed_reg;
        rem_next     = rem_reg;
        emitted_next = emitted_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        chan_next    = chan_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        n            = 2'd0;
        e0           = '0;
        e1           = '0;

        acc_shift = {acc_reg[23:0], in_byte_reg};
        cnt_inc   = cnt_reg + 5'd1;
        rem_dec   = rem_reg - 32'd1;
        col_inc   = {1'b0, col_reg} + 13'd1;
        row_inc   = {1'b0, row_reg} + 13'd1;
        size_sat  = (acc_shift > {19'd0, SIZE_SAT}) ? SIZE_SAT : acc_shift[12:0];
        pixel     = chan_pack(cfg.red, red_reg) | chan_pack(cfg.green, green_reg)
                  | chan_pack(cfg.blue, in_byte_reg);

        if (advance) begin
            if (in_req_reg == REQ_START) begin
                // any reply in progress is dropped without a result
                cnt_next     = 5'd0;
                acc_next     = 32'd0;
                status_next  = 32'd0;
                width_next   = 13'd0;
                height_next  = 13'd0;
                seed_next    = 32'd0;
                rem_next     = 32'd0;
                emitted_next = 9'd0;
                col_next     = 12'd0;
                row_next     = 12'd0;
                chan_next    = 2'd0;
                red_next     = 8'd0;
                green_next   = 8'd0;
                phase_next   = PH_HEAD;
            end else if (in_req_reg == REQ_END) begin
                if (phase_reg != PH_IDLE) begin
                    e0.kind    = KIND_CLOSED;
                    n          = 2'd1;
                    phase_next = PH_IDLE;
                end
            end else if (in_req_reg == REQ_DATA) begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_HEAD, PH_BADMAGIC: begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc;
                        if (cnt_inc == HDR_MAGIC_END && acc_shift != MAGIC_WORD) begin
                            phase_next = PH_BADMAGIC;
                        end
                        if (cnt_inc == HDR_STATUS_END) begin
                            status_next = acc_shift;
                            if (phase_reg == PH_BADMAGIC) begin
                                e0.kind    = KIND_BADMAG;
                                n          = 2'd1;
                                phase_next = PH_IDLE;
                            end else if (acc_shift != 32'd0) begin
                                phase_next = PH_ERRLEN;
                            end else begin
                                phase_next = PH_OKHDR;
                            end
                        end
                    end
                    PH_ERRLEN: begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc;
                        if (cnt_inc == HDR_WIDTH_END) begin
                            rem_next     = acc_shift;
                            emitted_next = 9'd0;
                            if (acc_shift == 32'd0) begin
                                e0.kind    = KIND_ERREND;
                                n          = 2'd1;
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_MSG;
                            end
                        end
                    end
                    PH_MSG: begin
                        rem_next = rem_dec;
                        if (emitted_reg < 9'(MSG_MAX)) begin
                            e0.kind         = KIND_MSG;
                            e0.message_byte = in_byte_reg;
                            emitted_next    = emitted_reg + 9'd1;
                            n               = 2'd1;
                        end
                        if (rem_dec == 32'd0) begin
                            // error end follows the message byte when there is one
                            if (n == 2'd0) e0.kind = KIND_ERREND;
                            else           e1.kind = KIND_ERREND;
                            n          = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_OKHDR: begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc;
                        if (cnt_inc == HDR_WIDTH_END) begin
                            width_next = size_sat;
                        end else if (cnt_inc == HDR_HEIGHT_END) begin
                            height_next = size_sat;
                        end else if (cnt_inc == HDR_SEED_END) begin
                            seed_next       = acc_shift;
                            e0.frame_width  = width_reg;
                            e0.frame_height = height_reg;
                            e0.frame_seed   = acc_shift;
                            if (width_reg > 13'(MAX_DIM) || height_reg > 13'(MAX_DIM)) begin
                                e0.kind    = KIND_OVERSZ;
                                n          = 2'd1;
                                phase_next = PH_IDLE;
                            end else if (width_reg == 13'd0 || height_reg == 13'd0) begin
                                e0.kind    = KIND_DONE;
                                n          = 2'd1;
                                phase_next = PH_IDLE;
                            end else begin
                                e0         = '0;
                                col_next   = 12'd0;
                                row_next   = 12'd0;
                                chan_next  = 2'd0;
                                phase_next = PH_PIX;
                            end
                        end
                    end
                    PH_PIX: begin
                        if (chan_reg == 2'd0) begin
                            red_next  = in_byte_reg;
                            chan_next = 2'd1;
                        end else if (chan_reg == 2'd1) begin
                            green_next = in_byte_reg;
                            chan_next  = 2'd2;
                        end else begin
                            e0.kind        = KIND_PIXEL;
                            e0.pixel_value = pixel;
                            e0.pixel_x     = col_reg;
                            e0.pixel_y     = row_reg;
                            n              = 2'd1;
                            chan_next      = 2'd0;
                            if (col_inc >= width_reg) begin
                                col_next = 12'd0;
                                if (row_inc >= height_reg) begin
                                    e1.kind         = KIND_DONE;
                                    e1.frame_width  = width_reg;
                                    e1.frame_height = height_reg;
                                    e1.frame_seed   = seed_reg;
                                    n               = 2'd2;
                                    phase_next      = PH_IDLE;
                                end else begin
                                    row_next = row_inc[11:0];
                                end
                            end else begin
                                col_next = col_inc[11:0];
                            end
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        // every result carries the status word as it stands after this beat
        e0.status_code = status_next;
        e1.status_code = status_next;
        e0.last        = (n == 2'd1);
        e1.last        = (n == 2'd2);
    end

    assign push.count  = n;
    assign push.first  = e0;
    assign push.second = e1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= 5'd0;
            acc_reg     <= 32'd0;
            status_reg  <= 32'd0;
            width_reg   <= 13'd0;
            height_reg  <= 13'd0;
            seed_reg    <= 32'd0;
            rem_reg     <= 32'd0;
            emitted_reg <= 9'd0;
            col_reg     <= 12'd0;
            row_reg     <= 12'd0;
            chan_reg    <= 2'd0;
            red_reg     <= 8'd0;
            green_reg   <= 8'd0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            status_reg  <= status_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            seed_reg    <= seed_next;
            rem_reg     <= rem_next;
            emitted_reg <= emitted_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            chan_reg    <= chan_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
        end
    end

    // raster position stays inside a frame that passed the size check
    a_pix_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIX |-> ({1'b0, col_reg} < width_reg && {1'b0, row_reg} < height_reg
                                 && width_reg <= 13'(MAX_DIM) && height_reg <= 13'(MAX_DIM)))
        else $error("pixel position outside frame");

    // header never runs past the status word without leaving the magic phases
    a_head_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_req_reg == REQ_DATA && cnt_reg == 5'd7
         && (phase_reg == PH_HEAD || phase_reg == PH_BADMAGIC))
        |=> (phase_reg != PH_HEAD && phase_reg != PH_BADMAGIC))
        else $error("header phase outlived status word");

    // message phase always has bytes still owed
    a_msg_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_MSG |-> rem_reg != 32'd0)
        else $error("message phase with nothing remaining");

endmodule

`default_nettype wire

/* hw/rtl/irdp_result_fifo.sv */
// small result queue: takes zero, one or two entries a cycle, gives one beat
// a cycle to the master side while out_ready is high; depends on irdp_pkg
`default_nettype none

module irdp_result_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire irdp_pkg::res_push_t  push,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output irdp_pkg::res_t            out_entry
);
    import irdp_pkg::*;

    // depth is a power of two so the pointers wrap on their own
    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    res_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic             pop;

    assign wr_ptr_inc = PTR_W'(wr_ptr_reg + 1'b1);
    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_entry  = slot_reg[rd_ptr_reg];
    // room for a two-result beat regardless of this cycle's pop
    assign room       = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push.count));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(push.count) - CNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) slot_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2) slot_reg[wr_ptr_inc] <= push.second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (int'(count_reg) + int'(push.count) - int'(pop) <= FIFO_DEPTH))
        else $error("result queue overflow");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (int'(count_reg) == int'($past(count_reg)) + int'($past(push.count))
                                - int'($past(pop))))
        else $error("result queue count drift");

endmodule

`default_nettype wire

/* hw/rtl/image_reply_deframer_pixel_packer_unit.sv */
// top level of the image reply deframer and pixel packer
// instantiates irdp_chan_cfg, irdp_parser and irdp_result_fifo; uses irdp_pkg
//
// usage
//  - slave stream: one beat per reply byte; s_tuser is the request code (data
//    byte, end of stream, start of reply), s_tdata the byte itself
//  - master stream: one beat per result; m_tuser is the result kind, m_tlast
//    marks the last result caused by one slave beat, m_tdata carries the
//    pixel, position, message byte, status word and frame sizes
//  - apb port: red, green and blue channel masks at 0x0, 0x4 and 0x8; write
//    them only while no reply is in flight
//  - order: a taken slave beat is held in the input register, parsed and
//    packed, then written into the result queue that feeds the master side
//  - throughput: one slave beat per cycle while the queue has room, set by
//    the combinational parse and pack path; a beat with two results (last
//    pixel with done, last message byte with error end) leaves as two beats
//  - stall: a four-entry result queue sits before the master side; the slave
//    side keeps taking beats while there is room for two more results, so a
//    stalled receiver backs up into s_tready once over two results wait
//  - reset: synchronous, active low; parser idle, queue empty, masks back to
//    8:8:8 rgb; no clearing pass is needed
`default_nettype none

module image_reply_deframer_pixel_packer_unit #(
    parameter int unsigned MAX_DIM = irdp_pkg::MAX_DIM_DEFAULT,
    parameter int unsigned MSG_MAX = irdp_pkg::MSG_MAX_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // slave stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // rx_byte
    input  wire logic [1:0]                       s_tuser,   // req_type
    // master stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // pixel_value[31:0], pixel_x[43:32], pixel_y[55:44], message_byte[63:56],
    // status_code[95:64], frame_width[108:96], frame_height[121:109],
    // frame_seed[153:122], zero fill above
    output logic [irdp_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [2:0]                            m_tuser,   // result_kind
    output logic                                  m_tlast,   // last_of_run
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [3:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);
    import irdp_pkg::*;

    pix_cfg_t  cfg;
    res_push_t push;
    logic      room;
    res_t      out_entry;

    // channel masks and their decoded shift and width
    irdp_chan_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // beat register, frame parsing and pixel packing
    irdp_parser #(
        .MAX_DIM (MAX_DIM),
        .MSG_MAX (MSG_MAX)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_req   (s_tuser),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .cfg      (cfg),
        .room     (room),
        .push     (push)
    );

    // results queue up here and leave one beat at a time
    irdp_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (out_entry)
    );

    // pack the result fields, pixel value in the lowest bits
    assign m_tdata = {{OUT_PAD_W{1'b0}},
                      out_entry.frame_seed,
                      out_entry.frame_height,
                      out_entry.frame_width,
                      out_entry.status_code,
                      out_entry.message_byte,
                      out_entry.pixel_y,
                      out_entry.pixel_x,
                      out_entry.pixel_value};
    assign m_tuser = out_entry.kind;
    assign m_tlast = out_entry.last;

endmodule

`default_nettype wire

/* sim/tb_image_reply_deframer_pixel_packer_unit.sv */
// testbench for image_reply_deframer_pixel_packer_unit: random and directed reply streams,
// result beats checked field by field against a built-in behavioural decoder
// depends on irdp_pkg and the rtl of the unit only
`timescale 1ns / 100ps

module tb_image_reply_deframer_pixel_packer_unit;
    import irdp_pkg::*;

    // request code with no meaning, the block must ignore it
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // long receiver hold-off, in cycles, to back the result queue up into s_tready
    localparam int HOLD_CYCLES = 200;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // rx_byte
    logic [1:0]  s_tuser  = REQ_DATA; // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pixel_value, pixel_x, pixel_y, message_byte, status_code, frame_width,
    // frame_height, frame_seed, zero fill above
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]  m_tuser;            // result_kind
    logic        m_tlast;            // last_of_run
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    image_reply_deframer_pixel_packer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // behavioural decoder: own copy of the parser state and channel masks
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        RX_IDLE, RX_HEADER, RX_BAD_MAGIC, RX_ERR_LEN, RX_MESSAGE, RX_OK_HEADER, RX_PIXELS
    } rx_phase_e;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data;
    } reply_beat_t;

    rx_phase_e   rx_phase = RX_IDLE;
    logic [4:0]  rx_hdr_count;
    logic [31:0] rx_word, rx_status, rx_seed, rx_msg_left;
    logic [12:0] rx_width, rx_height;
    logic [8:0]  rx_msg_sent;
    logic [11:0] rx_col, rx_row;
    logic [1:0]  rx_chan;
    logic [7:0]  rx_red, rx_green;
    logic [31:0] red_mask_now   = RED_MASK_RST;
    logic [31:0] green_mask_now = GREEN_MASK_RST;
    logic [31:0] blue_mask_now  = BLUE_MASK_RST;

    res_t        decoded_results[$];   // results owed by the block, oldest first
    reply_beat_t reply_beats[$];       // beats waiting for the driver
    reply_beat_t frame_draft[$];       // one reply being assembled
    int          beats_planned = 0;
    bit          mismatch_seen = 1'b0;

    task automatic clear_reply_state();
        rx_hdr_count = '0; rx_word = '0; rx_status = '0; rx_seed = '0;
        rx_width = '0; rx_height = '0; rx_msg_left = '0; rx_msg_sent = '0;
        rx_col = '0; rx_row = '0; rx_chan = '0; rx_red = '0; rx_green = '0;
    endtask

    // scale one colour byte to the run of ones in the mask and move it into place
    function automatic logic [31:0] place_channel(input logic [31:0] mask,
                                                  input logic [7:0] comp);
        logic [31:0] m;
        int          lsb;
        int          run;
        logic [63:0] scaled;
        m = mask;
        lsb = 0;
        run = 0;
        while (m != 0 && !m[0]) begin
            m = m >> 1;
            lsb++;
        end
        while (m[0]) begin
            m = m >> 1;
            run++;
        end
        if (run >= 8) scaled = 64'(comp) << (run - 8);
        else          scaled = 64'(comp) >> (8 - run);
        scaled = (scaled << lsb) & 64'(mask);
        return scaled[31:0];
    endfunction

    function automatic logic [12:0] clamp_size(input logic [31:0] v);
        return (v > 32'(SIZE_SAT)) ? SIZE_SAT : v[12:0];
    endfunction

    task automatic owe_result(input logic [2:0] kind, input logic [31:0] pix,
                              input logic [11:0] x, input logic [11:0] y,
                              input logic [7:0] msg, input logic [12:0] fw,
                              input logic [12:0] fh, input logic [31:0] sd);
        res_t r;
        r.kind = kind;
        r.pixel_value = pix;
        r.pixel_x = x;
        r.pixel_y = y;
        r.message_byte = msg;
        r.status_code = rx_status;
        r.frame_width = fw;
        r.frame_height = fh;
        r.frame_seed = sd;
        r.last = 1'b0;
        decoded_results.push_back(r);
    endtask

    // one accepted slave beat: advance the parser and queue what it gives
    task automatic decode_reply_byte(input logic [1:0] req, input logic [7:0] b);
        int          produced;
        logic [31:0] pix;
        produced = 0;
        if (req == REQ_START) begin
            // any reply in flight is dropped without a word
            clear_reply_state();
            rx_phase = RX_HEADER;
        end else if (req == REQ_END) begin
            if (rx_phase != RX_IDLE) begin
                owe_result(KIND_CLOSED, 0, 0, 0, 0, 0, 0, 0);
                produced++;
                rx_phase = RX_IDLE;
            end
        end else if (req == REQ_DATA && rx_phase != RX_IDLE) begin
            case (rx_phase)
                RX_HEADER, RX_BAD_MAGIC: begin
                    rx_word = {rx_word[23:0], b};
                    rx_hdr_count++;
                    if (rx_hdr_count == HDR_MAGIC_END && rx_word != MAGIC_WORD)
                        rx_phase = RX_BAD_MAGIC;
                    // a wrong magic is only reported once the status word is in
                    if (rx_hdr_count == HDR_STATUS_END) begin
                        rx_status = rx_word;
                        if (rx_phase == RX_BAD_MAGIC) begin
                            owe_result(KIND_BADMAG, 0, 0, 0, 0, 0, 0, 0);
                            produced++;
                            rx_phase = RX_IDLE;
                        end else begin
                            rx_phase = (rx_status != 0) ? RX_ERR_LEN : RX_OK_HEADER;
                        end
                    end
                end
                RX_ERR_LEN: begin
                    rx_word = {rx_word[23:0], b};
                    rx_hdr_count++;
                    if (rx_hdr_count == HDR_WIDTH_END) begin
                        rx_msg_left = rx_word;
                        rx_msg_sent = '0;
                        if (rx_msg_left == 0) begin
                            owe_result(KIND_ERREND, 0, 0, 0, 0, 0, 0, 0);
                            produced++;
                            rx_phase = RX_IDLE;
                        end else begin
                            rx_phase = RX_MESSAGE;
                        end
                    end
                end
                RX_MESSAGE: begin
                    // bytes past the message limit are swallowed
                    if (32'(rx_msg_sent) < MSG_MAX_DEFAULT) begin
                        owe_result(KIND_MSG, 0, 0, 0, b, 0, 0, 0);
                        produced++;
                        rx_msg_sent++;
                    end
                    rx_msg_left--;
                    if (rx_msg_left == 0) begin
                        owe_result(KIND_ERREND, 0, 0, 0, 0, 0, 0, 0);
                        produced++;
                        rx_phase = RX_IDLE;
                    end
                end
                RX_OK_HEADER: begin
                    rx_word = {rx_word[23:0], b};
                    rx_hdr_count++;
                    if (rx_hdr_count == HDR_WIDTH_END) begin
                        rx_width = clamp_size(rx_word);
                    end else if (rx_hdr_count == HDR_HEIGHT_END) begin
                        rx_height = clamp_size(rx_word);
                    end else if (rx_hdr_count == HDR_SEED_END) begin
                        rx_seed = rx_word;
                        if (32'(rx_width) > MAX_DIM_DEFAULT || 32'(rx_height) > MAX_DIM_DEFAULT)
                        begin
                            owe_result(KIND_OVERSZ, 0, 0, 0, 0, rx_width, rx_height, rx_seed);
                            produced++;
                            rx_phase = RX_IDLE;
                        end else if (rx_width == 0 || rx_height == 0) begin
                            owe_result(KIND_DONE, 0, 0, 0, 0, rx_width, rx_height, rx_seed);
                            produced++;
                            rx_phase = RX_IDLE;
                        end else begin
                            rx_col = '0;
                            rx_row = '0;
                            rx_chan = '0;
                            rx_phase = RX_PIXELS;
                        end
                    end
                end
                RX_PIXELS: begin
                    if (rx_chan == 2'd0) begin
                        rx_red = b;
                        rx_chan = 2'd1;
                    end else if (rx_chan == 2'd1) begin
                        rx_green = b;
                        rx_chan = 2'd2;
                    end else begin
                        pix = place_channel(red_mask_now, rx_red)
                            | place_channel(green_mask_now, rx_green)
                            | place_channel(blue_mask_now, b);
                        owe_result(KIND_PIXEL, pix, rx_col, rx_row, 0, 0, 0, 0);
                        produced++;
                        rx_chan = 2'd0;
                        if (int'(rx_col) + 1 >= int'(rx_width)) begin
                            rx_col = '0;
                            if (int'(rx_row) + 1 >= int'(rx_height)) begin
                                owe_result(KIND_DONE, 0, 0, 0, 0, rx_width, rx_height, rx_seed);
                                produced++;
                                rx_phase = RX_IDLE;
                            end else begin
                                rx_row++;
                            end
                        end else begin
                            rx_col++;
                        end
                    end
                end
                default: rx_phase = RX_IDLE;
            endcase
        end
        if (produced > 0)
            decoded_results[decoded_results.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of beats with random gaps, one nonblocking write per edge
    // ------------------------------------------------------------------
    int          gap_left   = 0;
    int          burst_left = 0;
    reply_beat_t next_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                decode_reply_byte(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (reply_beats.size() > 0) begin
                    next_beat = reply_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.data;
                    s_tuser  <= next_beat.req;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // end of a burst: a third of the time carry straight on
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks every result beat, stalls on its own changing pattern
    // ------------------------------------------------------------------
    int          results_checked = 0;
    int          hold_left    = 0;
    int          stall_mode   = 0;
    int          pattern_left = 0;
    logic [31:0] pattern_bits = '1;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_seen = 1'b1;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    task automatic check_result_beat();
        res_t want;
        if (decoded_results.size() == 0) begin
            mismatch_seen = 1'b1;
            $error("result beat kind %0d with nothing owed", m_tuser);
        end else begin
            want = decoded_results.pop_front();
            check_field("result_kind",  32'(want.kind),         32'(m_tuser));
            check_field("pixel_value",  want.pixel_value,       m_tdata[31:0]);
            check_field("pixel_x",      32'(want.pixel_x),      32'(m_tdata[43:32]));
            check_field("pixel_y",      32'(want.pixel_y),      32'(m_tdata[55:44]));
            check_field("message_byte", 32'(want.message_byte), 32'(m_tdata[63:56]));
            check_field("status_code",  want.status_code,       m_tdata[95:64]);
            check_field("frame_width",  32'(want.frame_width),  32'(m_tdata[108:96]));
            check_field("frame_height", 32'(want.frame_height), 32'(m_tdata[121:109]));
            check_field("frame_seed",   want.frame_seed,        m_tdata[153:122]);
            check_field("tdata_fill",   32'd0, 32'(m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]));
            check_field("last_of_run",  32'(want.last),         32'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result_beat();
                results_checked++;
                // twice in the run the receiver goes quiet for a long stretch
                if (results_checked == 60 || results_checked == 400)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    stall_mode   = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 96);
                    pattern_bits = $urandom();
                end else begin
                    pattern_left--;
                end
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: begin
                        m_tready <= pattern_bits[0];
                        pattern_bits = {pattern_bits[0], pattern_bits[31:1]};
                    end
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // reply builders
    // ------------------------------------------------------------------
    task automatic add_beat(input logic [1:0] req, input logic [7:0] d);
        reply_beat_t bt;
        bt.req = req;
        bt.data = d;
        frame_draft.push_back(bt);
    endtask

    // big-endian word
    task automatic add_word(input logic [31:0] w);
        add_beat(REQ_DATA, w[31:24]);
        add_beat(REQ_DATA, w[23:16]);
        add_beat(REQ_DATA, w[15:8]);
        add_beat(REQ_DATA, w[7:0]);
    endtask

    task automatic start_reply(input logic [31:0] status);
        frame_draft.delete();
        add_beat(REQ_START, 8'($urandom()));
        add_word(MAGIC_WORD);
        add_word(status);
    endtask

    // pixel bytes only follow when the sizes give a real image
    task automatic build_image(input logic [31:0] w, input logic [31:0] h,
                               input logic [31:0] sd);
        start_reply(32'd0);
        add_word(w);
        add_word(h);
        add_word(sd);
        if (w >= 1 && w <= MAX_DIM_DEFAULT && h >= 1 && h <= MAX_DIM_DEFAULT)
            repeat (int'(w) * int'(h) * 3) add_beat(REQ_DATA, 8'($urandom()));
    endtask

    task automatic build_error(input logic [31:0] status, input logic [31:0] len,
                               input int body);
        start_reply(status);
        add_word(len);
        repeat (body) add_beat(REQ_DATA, 8'($urandom()));
    endtask

    // magic spoilt in one byte or wholly random
    task automatic build_bad_magic();
        logic [31:0] bad;
        if ($urandom_range(0, 1) == 0)
            bad = MAGIC_WORD ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
        else
            bad = $urandom();
        if (bad == MAGIC_WORD) bad = bad ^ 32'd1;
        frame_draft.delete();
        add_beat(REQ_START, 8'($urandom()));
        add_word(bad);
        add_word($urandom());
    endtask

    // hand the draft to the driver, maybe cut short, maybe closed by end of stream
    task automatic commit_frame(input bit cut, input bit close);
        int keep;
        keep = frame_draft.size();
        if (cut && keep > 1) keep = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++) reply_beats.push_back(frame_draft[i]);
        beats_planned += keep;
        if (close) begin
            frame_draft.delete();
            add_beat(REQ_END, 8'($urandom()));
            reply_beats.push_back(frame_draft[0]);
            beats_planned++;
        end
    endtask

    function automatic logic [31:0] error_status();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'h8000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'd1;
            default: v = $urandom();
        endcase
        if (v == 0) v = 32'd1;
        return v;
    endfunction

    // mostly well-formed replies with random content, some cut, some noise
    task automatic random_replies(input int target);
        int          first;
        int          pick;
        bit          cut;
        int          len;
        logic [31:0] big;
        first = beats_planned;
        while (beats_planned - first < target) begin
            pick = $urandom_range(0, 99);
            cut  = ($urandom_range(0, 9) == 0);
            if (pick < 42) begin
                build_image($urandom_range(1, 4), $urandom_range(1, 3), $urandom());
                commit_frame(cut, cut && $urandom_range(0, 1));
            end else if (pick < 57) begin
                len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 6);
                build_error(error_status(), len, len);
                commit_frame(cut, cut && $urandom_range(0, 1));
            end else if (pick < 65) begin
                build_bad_magic();
                commit_frame(cut, cut && $urandom_range(0, 1));
            end else if (pick < 72) begin
                // empty image, the other size anything up to the limit
                if ($urandom_range(0, 1) == 0)
                    build_image(0, $urandom_range(0, MAX_DIM_DEFAULT), $urandom());
                else
                    build_image($urandom_range(0, MAX_DIM_DEFAULT), 0, $urandom());
                commit_frame(cut, cut);
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0:       big = MAX_DIM_DEFAULT + 1;
                    1:       big = 32'(SIZE_SAT);
                    2:       big = 32'(SIZE_SAT) + 1;
                    default: big = $urandom_range(MAX_DIM_DEFAULT + 1, 32'hFFFF_FFFF);
                endcase
                if ($urandom_range(0, 1) == 0)
                    build_image(big, $urandom_range(0, MAX_DIM_DEFAULT), $urandom());
                else
                    build_image($urandom_range(0, MAX_DIM_DEFAULT), big, $urandom());
                commit_frame(cut, cut);
            end else if (pick < 88) begin
                // left hanging, the next start of reply drops it
                build_image($urandom_range(1, 3), $urandom_range(1, 2), $urandom());
                commit_frame(1'b1, 1'b0);
            end else begin
                frame_draft.delete();
                repeat ($urandom_range(1, 5))
                    add_beat(2'($urandom_range(0, 3)), 8'($urandom()));
                commit_frame(1'b0, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // apb writes and phase boundaries
    // ------------------------------------------------------------------
    task automatic write_mask(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RED:   red_mask_now   = val;
            REG_GREEN: green_mask_now = val;
            default:   blue_mask_now  = val;
        endcase
    endtask

    // close any open reply, drain everything, then let the pipeline empty
    task automatic drain_replies();
        frame_draft.delete();
        add_beat(REQ_END, 8'h00);
        commit_frame(1'b0, 1'b0);
        while (!(reply_beats.size() == 0 && !s_tvalid && decoded_results.size() == 0))
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_masks(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b);
        write_mask(REG_RED, r);
        write_mask(REG_GREEN, g);
        write_mask(REG_BLUE, b);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle handling, unused code, early close, restart, bad magic
        frame_draft.delete();
        add_beat(REQ_END, 8'hFF);
        add_beat(REQ_DATA, 8'hFF);
        add_beat(REQ_UNUSED, 8'h00);
        add_beat(REQ_UNUSED, 8'hFF);
        add_beat(REQ_START, 8'h00);
        add_beat(REQ_END, 8'h00);
        add_beat(REQ_START, 8'hAA);
        add_beat(REQ_START, 8'h55);
        add_word(32'h0000_0000);
        add_word(32'hFFFF_FFFF);
        add_beat(REQ_START, 8'h00);
        add_beat(REQ_DATA, 8'h46);
        add_beat(REQ_END, 8'hFF);
        commit_frame(1'b0, 1'b0);

        // every way a reply can end, random content
        build_error(32'h8000_0000, 32'd0, 0);                 // zero length
        commit_frame(1'b0, 1'b0);
        build_error(32'h7FFF_FFFF, 32'd3, 3);
        commit_frame(1'b0, 1'b0);
        build_error(32'hFFFF_FFFF, MSG_MAX_DEFAULT + 4, MSG_MAX_DEFAULT + 4); // overflow
        commit_frame(1'b0, 1'b0);
        build_error(32'd1, 32'h8000_0000, 3);                 // huge message cut short
        commit_frame(1'b0, 1'b1);
        build_image(0, 5, $urandom());                        // empty width
        commit_frame(1'b0, 1'b0);
        build_image(7, 0, $urandom());                        // empty height
        commit_frame(1'b0, 1'b0);
        build_image(MAX_DIM_DEFAULT + 1, 1, $urandom());      // oversize
        commit_frame(1'b0, 1'b0);
        build_image(1, 32'hFFFF_FFFF, $urandom());            // saturated size
        commit_frame(1'b0, 1'b0);
        build_image(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        commit_frame(1'b0, 1'b0);
        build_image(1, 1, 32'hFFFF_FFFF);
        commit_frame(1'b0, 1'b0);
        build_image(3, 2, 32'd0);
        commit_frame(1'b0, 1'b0);
        build_bad_magic();
        commit_frame(1'b0, 1'b0);
        build_image(2, 2, $urandom());                        // dropped by restart
        commit_frame(1'b1, 1'b0);
        random_replies(30);
        drain_replies();

        // 5:6:5
        load_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
        random_replies(15);
        drain_replies();

        // extremes: full word, empty mask, single top bit
        load_masks(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        random_replies(15);
        drain_replies();

        // arbitrary, often gappy masks
        load_masks($urandom(), $urandom(), $urandom());
        random_replies(15);
        drain_replies();

        // 10 bits per channel, blue on top
        load_masks(32'h0000_03FF, 32'h000F_FC00, 32'h3FF0_0000);
        random_replies(15);
        drain_replies();

        repeat (10) @(posedge aclk);
        if (decoded_results.size() != 0)
            $error("%0d results never arrived", decoded_results.size());
        if (!mismatch_seen && decoded_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #(40_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
